@@ hw/rtl/tssd_pkg.sv @@
package tssd_pkg;

	// Door geometry.
	localparam int unsigned CLOSED_ANGLE   = 90;
	localparam int unsigned FULL_SWING_DEG = 90;
	localparam int unsigned MAX_ANGLE      = 180;
	localparam int unsigned MAX_FRACTION   = 1000;
	localparam int unsigned CLOSED_LIMIT   = 20;
	localparam int unsigned FULL_LIMIT     = 980;

	// Field widths.
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned FRAC_IN_W = 12;
	localparam int unsigned ANGLE_W = 8;
	localparam int unsigned FRAC_W  = 10;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// The swing is round(frac * FULL_SWING_DEG / 1000), taken as
	// floor((frac * FULL_SWING_DEG + 500) * RECIP >> RECIP_SHIFT).
	localparam int unsigned SWING_NUM_W = 18;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + 999) / 1000;
	localparam int unsigned RECIP_W     = 21;
	localparam int unsigned PROD_W      = SWING_NUM_W + RECIP_W;
	localparam int unsigned ROUND_HALF  = 500;

	// Queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Command codes on the input.
	localparam logic [CMD_W-1:0] CMD_TICK          = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START_COLLECT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_START_RELEASE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLOSE         = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MAN_COLLECT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_MAN_FULL      = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SET_OPEN      = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLLECT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLLECT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_FULL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_FULL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLLECT_FRAC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS       = 3'd6;

	// Phase codes as reported on the output.
	localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_C_OPEN  = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_C_HOLD  = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_C_CLOSE = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_R_OPEN  = 3'd4;
	localparam logic [PHASE_W-1:0] PHASE_R_HOLD  = 3'd5;

	// Operation classes handed from front to back.
	typedef enum logic [2:0] {
		OP_TICK,
		OP_START_COLLECT,
		OP_START_RELEASE,
		OP_CLOSE,
		OP_MAN_COLLECT,
		OP_MAN_FULL,
		OP_SET_OPEN,
		OP_NOP
	} op_t;

	// One queued item.
	typedef struct packed {
		op_t                    op;
		logic [FRAC_W-1:0]      frac;
		logic [SWING_NUM_W-1:0] swing_num;
	} entry_t;

	// Configuration write.
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

@@ hw/rtl/twin_servo_door_sequencer.sv @@
// Channel   | Direction | Handshake             | Payload
// input     | in        | in_valid / in_ready   | cmd, open_fraction, fraction_invalid
// result    | out       | out_valid / out_ready | left_angle, right_angle, phase, open_now,
//           |           |                       | door_closed, door_full, idle_flag, accepted
// config    | in        | cfg_we                | cfg_index, cfg_wdata
//
// One item per cycle is sustained while out_ready holds; an input passes through the queue slot
// and then the sequencer state register before its result is offered.
// The sequencer state doubles as the result register, so the back end takes the next
// queued item in the same cycle the previous result is transferred.
// When the output stalls, up to two items collect in the queue before in_ready drops.
// Reset is asynchronous and restores the closed pose, idle phase and register defaults.
module twin_servo_door_sequencer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [tssd_pkg::CMD_W-1:0]             cmd,
	input  logic signed [tssd_pkg::FRAC_IN_W-1:0]  open_fraction,
	input  logic                                   fraction_invalid,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [tssd_pkg::ANGLE_W-1:0]           left_angle,
	output logic [tssd_pkg::ANGLE_W-1:0]           right_angle,
	output logic [tssd_pkg::PHASE_W-1:0]           phase,
	output logic [tssd_pkg::FRAC_W-1:0]            open_now,
	output logic                                   door_closed,
	output logic                                   door_full,
	output logic                                   idle_flag,
	output logic                                   accepted,
	input  logic                                   cfg_we,
	input  logic [tssd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tssd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	tssd_pkg::queue_status_t qstat;
	tssd_pkg::entry_t        push_entry;
	tssd_pkg::entry_t        head_entry;
	tssd_pkg::cfg_wr_t       cfg;
	logic                    push;
	logic                    pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_wdata;

	// Front end: transfer and classify.
	tssd_front u_front (
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.open_fraction    (open_fraction),
		.fraction_invalid (fraction_invalid),
		.qstat            (qstat),
		.push             (push),
		.push_entry       (push_entry)
	);

	// Decoupling queue.
	tssd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.qstat      (qstat)
	);

	// Back end: sequencer and result.
	tssd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.qstat       (qstat),
		.head_entry  (head_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_angle  (left_angle),
		.right_angle (right_angle),
		.phase       (phase),
		.open_now    (open_now),
		.door_closed (door_closed),
		.door_full   (door_full),
		.idle_flag   (idle_flag),
		.accepted    (accepted)
	);

endmodule

@@ hw/rtl/tssd_front.sv @@
module tssd_front (
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [tssd_pkg::CMD_W-1:0]            cmd,
	input  logic signed [tssd_pkg::FRAC_IN_W-1:0] open_fraction,
	input  logic                                  fraction_invalid,
	input  tssd_pkg::queue_status_t               qstat,
	output logic                                  push,
	output tssd_pkg::entry_t                      push_entry
);

	logic [tssd_pkg::FRAC_W-1:0] frac_clamped;

	// Take a new item whenever the queue has room.
	assign in_ready = !qstat.full;
	assign push     = in_valid && !qstat.full;

	// Clamp the requested fraction to the legal permille range.
	always_comb begin
		if (open_fraction < 0) begin
			frac_clamped = '0;
		end else if (open_fraction > $signed(tssd_pkg::FRAC_IN_W'(tssd_pkg::MAX_FRACTION))) begin
			frac_clamped = tssd_pkg::FRAC_W'(tssd_pkg::MAX_FRACTION);
		end else begin
			frac_clamped = open_fraction[tssd_pkg::FRAC_W-1:0];
		end
	end

	// Classify the command and prepare the rounded swing numerator.
	always_comb begin
		push_entry.frac      = frac_clamped;
		push_entry.swing_num = tssd_pkg::SWING_NUM_W'(frac_clamped)
			* tssd_pkg::SWING_NUM_W'(tssd_pkg::FULL_SWING_DEG)
			+ tssd_pkg::SWING_NUM_W'(tssd_pkg::ROUND_HALF);
		case (cmd)
			tssd_pkg::CMD_TICK:          push_entry.op = tssd_pkg::OP_TICK;
			tssd_pkg::CMD_START_COLLECT: push_entry.op = tssd_pkg::OP_START_COLLECT;
			tssd_pkg::CMD_START_RELEASE: push_entry.op = tssd_pkg::OP_START_RELEASE;
			tssd_pkg::CMD_CLOSE:         push_entry.op = tssd_pkg::OP_CLOSE;
			tssd_pkg::CMD_MAN_COLLECT:   push_entry.op = tssd_pkg::OP_MAN_COLLECT;
			tssd_pkg::CMD_MAN_FULL:      push_entry.op = tssd_pkg::OP_MAN_FULL;
			tssd_pkg::CMD_SET_OPEN: begin
				push_entry.op = fraction_invalid ? tssd_pkg::OP_NOP : tssd_pkg::OP_SET_OPEN;
			end
			default:                     push_entry.op = tssd_pkg::OP_NOP;
		endcase
	end

endmodule

@@ hw/rtl/tssd_queue.sv @@
module tssd_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tssd_pkg::entry_t        push_entry,
	input  logic                    pop,
	output tssd_pkg::entry_t        head_entry,
	output tssd_pkg::queue_status_t qstat
);

	tssd_pkg::entry_t                 mem_q [tssd_pkg::QUEUE_DEPTH];
	logic [tssd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [tssd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [tssd_pkg::QCNT_W-1:0]      count_q;

	assign qstat.full  = (count_q == tssd_pkg::QCNT_W'(tssd_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_entry  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tssd_pkg::QPTR_W'(tssd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == tssd_pkg::QPTR_W'(tssd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/tssd_back.sv @@
module tssd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tssd_pkg::cfg_wr_t                   cfg,
	input  tssd_pkg::queue_status_t             qstat,
	input  tssd_pkg::entry_t                    head_entry,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tssd_pkg::ANGLE_W-1:0]        left_angle,
	output logic [tssd_pkg::ANGLE_W-1:0]        right_angle,
	output logic [tssd_pkg::PHASE_W-1:0]        phase,
	output logic [tssd_pkg::FRAC_W-1:0]         open_now,
	output logic                                door_closed,
	output logic                                door_full,
	output logic                                idle_flag,
	output logic                                accepted
);

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_C_OPEN  = 6'b000010,
		PH_C_HOLD  = 6'b000100,
		PH_C_CLOSE = 6'b001000,
		PH_R_OPEN  = 6'b010000,
		PH_R_HOLD  = 6'b100000
	} phase_t;

	localparam logic [tssd_pkg::ANGLE_W-1:0] MAX_ANG = tssd_pkg::ANGLE_W'(tssd_pkg::MAX_ANGLE);
	localparam logic [tssd_pkg::FRAC_W-1:0]  MAX_FR  = tssd_pkg::FRAC_W'(tssd_pkg::MAX_FRACTION);
	localparam logic [tssd_pkg::ANGLE_W-1:0] CL_ANG  = tssd_pkg::ANGLE_W'(tssd_pkg::CLOSED_ANGLE);

	// Configuration registers.
	logic [tssd_pkg::ANGLE_W-1:0] left_collect_q, right_collect_q;
	logic [tssd_pkg::ANGLE_W-1:0] left_full_q, right_full_q;
	logic [tssd_pkg::FRAC_W-1:0]  collect_frac_q;
	logic [tssd_pkg::MS_W-1:0]    settle_ms_q, hold_ms_q;

	// Sequencer state; it also serves as the result register.
	phase_t                       phase_q, phase_d;
	logic [tssd_pkg::MS_W-1:0]    elapsed_q, elapsed_d;
	logic [tssd_pkg::ANGLE_W-1:0] left_q, left_d, right_q, right_d;
	logic [tssd_pkg::FRAC_W-1:0]  level_q, level_d;
	logic                         accepted_q, accepted_d;
	logic                         out_valid_q;

	logic [tssd_pkg::MS_W-1:0]    elapsed_inc;
	logic [tssd_pkg::PROD_W-1:0]  swing_prod;
	logic [tssd_pkg::ANGLE_W-1:0] swing;
	logic [tssd_pkg::ANGLE_W:0]   right_open_sum;
	logic [tssd_pkg::ANGLE_W-1:0] set_left, set_right;
	logic [tssd_pkg::ANGLE_W-1:0] coll_left, coll_right, full_left, full_right;
	logic [tssd_pkg::FRAC_W-1:0]  coll_frac;

	// Take the next item when the result slot is free or being emptied.
	assign pop       = !qstat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_collect_q  <= 8'd37;
			right_collect_q <= 8'd142;
			left_full_q     <= 8'd0;
			right_full_q    <= 8'd180;
			collect_frac_q  <= 10'd588;
			settle_ms_q     <= 16'd300;
			hold_ms_q       <= 16'd1200;
		end else if (cfg.we) begin
			case (cfg.index)
				tssd_pkg::CFG_LEFT_COLLECT:  left_collect_q  <= cfg.data[tssd_pkg::ANGLE_W-1:0];
				tssd_pkg::CFG_RIGHT_COLLECT: right_collect_q <= cfg.data[tssd_pkg::ANGLE_W-1:0];
				tssd_pkg::CFG_LEFT_FULL:     left_full_q     <= cfg.data[tssd_pkg::ANGLE_W-1:0];
				tssd_pkg::CFG_RIGHT_FULL:    right_full_q    <= cfg.data[tssd_pkg::ANGLE_W-1:0];
				tssd_pkg::CFG_COLLECT_FRAC:  collect_frac_q  <= cfg.data[tssd_pkg::FRAC_W-1:0];
				tssd_pkg::CFG_SETTLE_MS:     settle_ms_q     <= cfg.data[tssd_pkg::MS_W-1:0];
				tssd_pkg::CFG_HOLD_MS:       hold_ms_q       <= cfg.data[tssd_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Poses with out-of-range register values clamped.
	assign coll_left  = (left_collect_q  > MAX_ANG) ? MAX_ANG : left_collect_q;
	assign coll_right = (right_collect_q > MAX_ANG) ? MAX_ANG : right_collect_q;
	assign full_left  = (left_full_q     > MAX_ANG) ? MAX_ANG : left_full_q;
	assign full_right = (right_full_q    > MAX_ANG) ? MAX_ANG : right_full_q;
	assign coll_frac  = (collect_frac_q  > MAX_FR)  ? MAX_FR  : collect_frac_q;

	// Rounded swing by reciprocal multiplication, then the set-open angles.
	assign swing_prod = tssd_pkg::PROD_W'(head_entry.swing_num)
		* tssd_pkg::PROD_W'(tssd_pkg::RECIP);
	assign swing          = swing_prod[tssd_pkg::RECIP_SHIFT +: tssd_pkg::ANGLE_W];
	assign set_left       = (CL_ANG >= swing) ? CL_ANG - swing : '0;
	assign right_open_sum = {1'b0, CL_ANG} + {1'b0, swing};
	assign set_right      = (right_open_sum > {1'b0, MAX_ANG}) ? MAX_ANG
		: right_open_sum[tssd_pkg::ANGLE_W-1:0];

	// Saturating millisecond count.
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	// Next state for the item at the queue head.
	always_comb begin
		phase_d    = phase_q;
		elapsed_d  = elapsed_q;
		left_d     = left_q;
		right_d    = right_q;
		level_d    = level_q;
		accepted_d = 1'b1;
		case (head_entry.op)
			tssd_pkg::OP_TICK: begin
				elapsed_d = elapsed_inc;
				case (phase_q)
					PH_C_OPEN: begin
						if (elapsed_inc >= settle_ms_q) begin
							phase_d   = PH_C_HOLD;
							elapsed_d = '0;
						end
					end
					PH_C_HOLD: begin
						if (elapsed_inc >= hold_ms_q) begin
							phase_d   = PH_C_CLOSE;
							elapsed_d = '0;
							left_d    = CL_ANG;
							right_d   = CL_ANG;
							level_d   = '0;
						end
					end
					PH_C_CLOSE: begin
						if (elapsed_inc >= settle_ms_q) begin
							phase_d = PH_IDLE;
						end
					end
					PH_R_OPEN: begin
						if (elapsed_inc >= settle_ms_q) begin
							phase_d   = PH_R_HOLD;
							elapsed_d = '0;
						end
					end
					PH_R_HOLD: phase_d = PH_IDLE;
					default: ;
				endcase
			end
			tssd_pkg::OP_START_COLLECT: begin
				if (phase_q != PH_IDLE) begin
					accepted_d = 1'b0;
				end else begin
					left_d    = coll_left;
					right_d   = coll_right;
					level_d   = coll_frac;
					phase_d   = PH_C_OPEN;
					elapsed_d = '0;
				end
			end
			tssd_pkg::OP_START_RELEASE: begin
				if (phase_q != PH_IDLE) begin
					accepted_d = 1'b0;
				end else begin
					left_d    = full_left;
					right_d   = full_right;
					level_d   = MAX_FR;
					phase_d   = PH_R_OPEN;
					elapsed_d = '0;
				end
			end
			tssd_pkg::OP_CLOSE: begin
				left_d  = CL_ANG;
				right_d = CL_ANG;
				level_d = '0;
				phase_d = PH_IDLE;
			end
			tssd_pkg::OP_MAN_COLLECT: begin
				left_d  = coll_left;
				right_d = coll_right;
				level_d = coll_frac;
				phase_d = PH_IDLE;
			end
			tssd_pkg::OP_MAN_FULL: begin
				left_d  = full_left;
				right_d = full_right;
				level_d = MAX_FR;
				phase_d = PH_IDLE;
			end
			tssd_pkg::OP_SET_OPEN: begin
				left_d  = set_left;
				right_d = set_right;
				level_d = head_entry.frac;
				phase_d = PH_IDLE;
			end
			default: ;
		endcase
	end

	// State update and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			elapsed_q   <= '0;
			left_q      <= CL_ANG;
			right_q     <= CL_ANG;
			level_q     <= '0;
			accepted_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q    <= phase_d;
				elapsed_q  <= elapsed_d;
				left_q     <= left_d;
				right_q    <= right_d;
				level_q    <= level_d;
				accepted_q <= accepted_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result fields from the held state.
	always_comb begin
		case (phase_q)
			PH_IDLE:    phase = tssd_pkg::PHASE_IDLE;
			PH_C_OPEN:  phase = tssd_pkg::PHASE_C_OPEN;
			PH_C_HOLD:  phase = tssd_pkg::PHASE_C_HOLD;
			PH_C_CLOSE: phase = tssd_pkg::PHASE_C_CLOSE;
			PH_R_OPEN:  phase = tssd_pkg::PHASE_R_OPEN;
			PH_R_HOLD:  phase = tssd_pkg::PHASE_R_HOLD;
			default:    phase = tssd_pkg::PHASE_IDLE;
		endcase
	end

	assign left_angle  = left_q;
	assign right_angle = right_q;
	assign open_now    = level_q;
	assign door_closed = (level_q <= tssd_pkg::FRAC_W'(tssd_pkg::CLOSED_LIMIT));
	assign door_full   = (level_q >= tssd_pkg::FRAC_W'(tssd_pkg::FULL_LIMIT));
	assign idle_flag   = (phase_q == PH_IDLE);
	assign accepted    = accepted_q;

endmodule

@@ hw/rtl/tssd_checker.sv @@
module tssd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [tssd_pkg::ANGLE_W-1:0]      left_angle,
	input logic [tssd_pkg::ANGLE_W-1:0]      right_angle,
	input logic [tssd_pkg::PHASE_W-1:0]      phase,
	input logic                              idle_flag,
	input logic                              accepted
);

	// A stalled result keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// The idle flag agrees with the reported phase.
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idle_flag == (phase == tssd_pkg::PHASE_IDLE)))
		else $error("idle flag and phase disagree");

	// A refused start leaves a running sequence in place.
	a_refused_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> !idle_flag)
		else $error("start refused while idle");

	// Commanded angles never leave the servo range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_angle <= tssd_pkg::ANGLE_W'(tssd_pkg::MAX_ANGLE))
			&& (right_angle <= tssd_pkg::ANGLE_W'(tssd_pkg::MAX_ANGLE)))
		else $error("commanded angle out of range");

endmodule

bind twin_servo_door_sequencer tssd_checker u_tssd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.left_angle  (left_angle),
	.right_angle (right_angle),
	.phase       (phase),
	.idle_flag   (idle_flag),
	.accepted    (accepted)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import tssd_pkg::*;

	// Command code that the block must ignore.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int unsigned LONG_HOLD  = 80;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	// One observed or predicted result transfer.
	typedef struct {
		logic [ANGLE_W-1:0] left_angle;
		logic [ANGLE_W-1:0] right_angle;
		logic [PHASE_W-1:0] phase;
		logic [FRAC_W-1:0]  open_now;
		logic               door_closed;
		logic               door_full;
		logic               idle_flag;
		logic               accepted;
	} door_pose_t;

	// Tracks the door sequencer state and holds the poses still owed by the block.
	class door_scoreboard;
		logic [ANGLE_W-1:0] left_collect, right_collect, left_full, right_full;
		logic [FRAC_W-1:0]  collect_frac;
		logic [MS_W-1:0]    settle, hold;
		logic [PHASE_W-1:0] seq;
		logic [MS_W-1:0]    elapsed;
		logic [ANGLE_W-1:0] left, right;
		logic [FRAC_W-1:0]  level;
		door_pose_t         pose_queue[$];
		int                 errors;

		function new();
			left_collect  = 37;
			right_collect = 142;
			left_full     = 0;
			right_full    = 180;
			collect_frac  = 588;
			settle        = 300;
			hold          = 1200;
			seq           = PHASE_IDLE;
			elapsed       = '0;
			errors        = 0;
			set_pose(CLOSED_ANGLE, CLOSED_ANGLE, 0);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_LEFT_COLLECT:  left_collect  = val[ANGLE_W-1:0];
				CFG_RIGHT_COLLECT: right_collect = val[ANGLE_W-1:0];
				CFG_LEFT_FULL:     left_full     = val[ANGLE_W-1:0];
				CFG_RIGHT_FULL:    right_full    = val[ANGLE_W-1:0];
				CFG_COLLECT_FRAC:  collect_frac  = val[FRAC_W-1:0];
				CFG_SETTLE_MS:     settle        = val[MS_W-1:0];
				CFG_HOLD_MS:       hold          = val[MS_W-1:0];
				default: ;
			endcase
		endfunction

		// Angles saturate at the servo limit, the fraction at full open.
		function void set_pose(int unsigned l, int unsigned r, int unsigned f);
			left  = ANGLE_W'((l > MAX_ANGLE) ? MAX_ANGLE : l);
			right = ANGLE_W'((r > MAX_ANGLE) ? MAX_ANGLE : r);
			level = FRAC_W'((f > MAX_FRACTION) ? MAX_FRACTION : f);
		endfunction

		// One millisecond passes: count, then at most one timed phase change.
		function void advance_ms();
			if (elapsed != '1)
				elapsed++;
			case (seq)
				PHASE_C_OPEN: if (elapsed >= settle) begin
					seq = PHASE_C_HOLD;
					elapsed = '0;
				end
				PHASE_C_HOLD: if (elapsed >= hold) begin
					set_pose(CLOSED_ANGLE, CLOSED_ANGLE, 0);
					seq = PHASE_C_CLOSE;
					elapsed = '0;
				end
				PHASE_C_CLOSE: if (elapsed >= settle)
					seq = PHASE_IDLE;
				PHASE_R_OPEN: if (elapsed >= settle) begin
					seq = PHASE_R_HOLD;
					elapsed = '0;
				end
				PHASE_R_HOLD: seq = PHASE_IDLE;
				default: ;
			endcase
		endfunction

		// Proportional open: clamp, round the swing half up, mirror around closed.
		function void apply_fraction(logic signed [FRAC_IN_W-1:0] raw);
			int          f;
			int unsigned swing;
			f = raw;
			if (f < 0)
				f = 0;
			if (f > MAX_FRACTION)
				f = MAX_FRACTION;
			swing = (f * FULL_SWING_DEG + ROUND_HALF) / MAX_FRACTION;
			set_pose((CLOSED_ANGLE >= swing) ? CLOSED_ANGLE - swing : 0,
				CLOSED_ANGLE + swing, f);
			seq = PHASE_IDLE;
		endfunction

		// Applies one accepted command and queues the pose it leads to.
		function void note_command(logic [CMD_W-1:0] c, logic signed [FRAC_IN_W-1:0] frac,
				logic inv);
			door_pose_t want;
			logic       ok;
			ok = 1'b1;
			case (c)
				CMD_TICK: advance_ms();
				CMD_START_COLLECT: if (seq != PHASE_IDLE) begin
					ok = 1'b0;
				end else begin
					set_pose(left_collect, right_collect, collect_frac);
					seq = PHASE_C_OPEN;
					elapsed = '0;
				end
				CMD_START_RELEASE: if (seq != PHASE_IDLE) begin
					ok = 1'b0;
				end else begin
					set_pose(left_full, right_full, MAX_FRACTION);
					seq = PHASE_R_OPEN;
					elapsed = '0;
				end
				CMD_CLOSE: begin
					set_pose(CLOSED_ANGLE, CLOSED_ANGLE, 0);
					seq = PHASE_IDLE;
				end
				CMD_MAN_COLLECT: begin
					set_pose(left_collect, right_collect, collect_frac);
					seq = PHASE_IDLE;
				end
				CMD_MAN_FULL: begin
					set_pose(left_full, right_full, MAX_FRACTION);
					seq = PHASE_IDLE;
				end
				CMD_SET_OPEN: if (!inv)
					apply_fraction(frac);
				default: ;
			endcase
			want.left_angle  = left;
			want.right_angle = right;
			want.phase       = seq;
			want.open_now    = level;
			want.door_closed = (level <= CLOSED_LIMIT);
			want.door_full   = (level >= FULL_LIMIT);
			want.idle_flag   = (seq == PHASE_IDLE);
			want.accepted    = ok;
			pose_queue.push_back(want);
		endfunction

		function void match_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Compares one result transfer with the oldest owed pose.
		function void check_pose(door_pose_t got);
			door_pose_t want;
			if (pose_queue.size() == 0) begin
				$error("result transfer with no expected pose outstanding");
				errors++;
				return;
			end
			want = pose_queue.pop_front();
			match_field("left_angle", want.left_angle, got.left_angle);
			match_field("right_angle", want.right_angle, got.right_angle);
			match_field("phase", want.phase, got.phase);
			match_field("open_now", want.open_now, got.open_now);
			match_field("door_closed", want.door_closed, got.door_closed);
			match_field("door_full", want.door_full, got.door_full);
			match_field("idle_flag", want.idle_flag, got.idle_flag);
			match_field("accepted", want.accepted, got.accepted);
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [CMD_W-1:0]            cmd = CMD_TICK;
	logic signed [FRAC_IN_W-1:0] open_fraction = '0;
	logic                        fraction_invalid = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [ANGLE_W-1:0]          left_angle, right_angle;
	logic [PHASE_W-1:0]          phase;
	logic [FRAC_W-1:0]           open_now;
	logic                        door_closed, door_full, idle_flag, accepted;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = CFG_LEFT_COLLECT;
	logic [CFG_DATA_W-1:0]       cfg_wdata = '0;

	door_scoreboard sb;
	bit             idle_en = 1'b1;
	bit             long_hold_due = 1'b0;
	int unsigned    cycles = 0;

	twin_servo_door_sequencer dut (.*);

	always #2 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Every result transfer is checked against the prediction.
	always @(posedge clk) begin : result_monitor
		door_pose_t got;
		if (arst_n && out_valid && out_ready) begin
			got.left_angle  = left_angle;
			got.right_angle = right_angle;
			got.phase       = phase;
			got.open_now    = open_now;
			got.door_closed = door_closed;
			got.door_full   = door_full;
			got.idle_flag   = idle_flag;
			got.accepted    = accepted;
			sb.check_pose(got);
		end
	end

	// Result side: random stall bursts, plus one long hold-off to back the block up.
	initial begin : result_sink
		int n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_due) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_due = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 17);
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one command, with an optional gap first, and waits for its transfer.
	task automatic send_item(logic [CMD_W-1:0] c, logic signed [FRAC_IN_W-1:0] f, logic inv);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		cmd              <= c;
		open_fraction    <= f;
		fraction_invalid <= inv;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_command(c, f, inv);
	endtask

	function automatic logic signed [FRAC_IN_W-1:0] rand_fraction();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return FRAC_IN_W'($urandom_range(0, 4095));
			4, 5, 6:    return FRAC_IN_W'($urandom_range(0, 1000));
			default: begin
				case ($urandom_range(0, 7))
					0: return FRAC_IN_W'(-2048);
					1: return FRAC_IN_W'(-1);
					2: return 0;
					3: return 1;
					4: return 999;
					5: return 1000;
					6: return 1001;
					default: return 2047;
				endcase
			end
		endcase
	endfunction

	function automatic logic [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return ANGLE_W'(MAX_ANGLE);
			2: return 255;
			default: return ANGLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_ticks(int n);
		repeat (n) send_item(CMD_TICK, rand_fraction(), 1'($urandom_range(0, 1)));
	endtask

	// Any command at all, ticks and set open weighted up.
	task automatic send_noise();
		logic [CMD_W-1:0] c;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 30)
			c = CMD_TICK;
		else if (r < 42)
			c = CMD_START_COLLECT;
		else if (r < 54)
			c = CMD_START_RELEASE;
		else if (r < 62)
			c = CMD_CLOSE;
		else if (r < 70)
			c = CMD_MAN_COLLECT;
		else if (r < 78)
			c = CMD_MAN_FULL;
		else if (r < 94)
			c = CMD_SET_OPEN;
		else
			c = CMD_UNUSED;
		send_item(c, rand_fraction(), $urandom_range(0, 4) == 0);
	endtask

	// Mostly started sequences followed by up to enough ticks to run them, with stray commands.
	task automatic random_batch(int n);
		int sent, k;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) < 7) begin
				send_item(($urandom_range(0, 1) != 0) ? CMD_START_COLLECT : CMD_START_RELEASE,
					rand_fraction(), 1'($urandom_range(0, 1)));
				k = $urandom_range(0, 2 * sb.settle + sb.hold + 4);
				sent += k + 1;
				repeat (k) begin
					if ($urandom_range(0, 11) == 0)
						send_noise();
					else
						send_item(CMD_TICK, rand_fraction(), 1'($urandom_range(0, 1)));
				end
			end else begin
				send_noise();
				sent++;
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic config_all(logic [ANGLE_W-1:0] lc, logic [ANGLE_W-1:0] rc,
			logic [ANGLE_W-1:0] lf, logic [ANGLE_W-1:0] rf, logic [FRAC_W-1:0] cf,
			logic [MS_W-1:0] st, logic [MS_W-1:0] hd);
		write_reg(CFG_LEFT_COLLECT, lc);
		write_reg(CFG_RIGHT_COLLECT, rc);
		write_reg(CFG_LEFT_FULL, lf);
		write_reg(CFG_RIGHT_FULL, rf);
		write_reg(CFG_COLLECT_FRAC, cf);
		write_reg(CFG_SETTLE_MS, st);
		write_reg(CFG_HOLD_MS, hd);
		cfg_we <= 1'b0;
	endtask

	// Stop offering, let every owed pose arrive, then cover the pipeline latency.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pose_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int          b;
		logic [FRAC_W-1:0] cf;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: set open extremes, rounding, thresholds, manual poses.
		send_item(CMD_TICK, 0, 1'b0);
		send_item(CMD_SET_OPEN, -2048, 1'b0);
		send_item(CMD_SET_OPEN, 2047, 1'b0);
		send_item(CMD_SET_OPEN, 50, 1'b0);
		send_item(CMD_SET_OPEN, 150, 1'b0);
		send_item(CMD_SET_OPEN, 1001, 1'b0);
		send_item(CMD_SET_OPEN, -1, 1'b0);
		send_item(CMD_SET_OPEN, 20, 1'b0);
		send_item(CMD_SET_OPEN, 21, 1'b0);
		send_item(CMD_SET_OPEN, 980, 1'b0);
		send_item(CMD_MAN_COLLECT, 0, 1'b0);
		send_item(CMD_MAN_FULL, 0, 1'b0);
		send_item(CMD_CLOSE, 0, 1'b0);
		// A start while busy is refused; a broken fraction leaves the sequence alone.
		send_item(CMD_START_COLLECT, 0, 1'b0);
		send_item(CMD_START_RELEASE, 0, 1'b0);
		send_item(CMD_SET_OPEN, 500, 1'b1);
		send_item(CMD_UNUSED, -2048, 1'b1);
		send_item(CMD_SET_OPEN, 1000, 1'b0);
		send_item(CMD_START_RELEASE, 0, 1'b0);
		send_item(CMD_CLOSE, 0, 1'b0);

		// Out-of-range pose registers and short timing: walk both sequences to idle.
		drain();
		config_all(255, 0, ANGLE_W'(MAX_ANGLE), 255, 1023, 1, 2);
		send_item(CMD_START_COLLECT, 0, 1'b0);
		send_ticks(4);
		send_item(CMD_START_RELEASE, 0, 1'b0);
		send_ticks(2);

		// Random settings per batch; the first batch also backs the block up.
		for (b = 0; b < 16; b++) begin
			drain();
			case ($urandom_range(0, 3))
				0: cf = 0;
				1: cf = FRAC_W'(MAX_FRACTION);
				2: cf = 1023;
				default: cf = FRAC_W'($urandom_range(0, 1023));
			endcase
			config_all(pick_angle(), pick_angle(), pick_angle(), pick_angle(), cf,
				MS_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)),
				MS_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20)));
			idle_en = (b < 12) && ($urandom_range(0, 3) != 0);
			if (b == 0) begin
				idle_en = 1'b1;
				long_hold_due = 1'b1;
			end
			random_batch(110);
		end

		// Longest settle: a release stays in its opening phase.
		drain();
		config_all(0, ANGLE_W'(MAX_ANGLE), ANGLE_W'(MAX_ANGLE), 0, FRAC_W'(MAX_FRACTION),
			'1, 0);
		send_item(CMD_START_RELEASE, 0, 1'b0);
		send_ticks(60);

		// Longest hold inside a collect.
		drain();
		config_all(ANGLE_W'(MAX_ANGLE), 0, 0, ANGLE_W'(MAX_ANGLE), 500, 1, '1);
		send_item(CMD_START_COLLECT, 0, 1'b0);
		send_ticks(60);

		drain();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/tssd_pkg.sv
hw/rtl/tssd_front.sv
hw/rtl/tssd_queue.sv
hw/rtl/tssd_back.sv
hw/rtl/twin_servo_door_sequencer.sv
hw/rtl/tssd_checker.sv
dv/testbench.sv
